>>> src/ird_pkg.sv
// Shared types and constants for the indexed ring deque.
package ird_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int WORD_W = 64;
   localparam int POS_W = 5;
   localparam int LEN_W = 5;

   typedef enum logic [2:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_BACK   = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_GET        = 3'd4,
      KIND_SET        = 3'd5,
      KIND_REMOVE     = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DELIVER
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_PULL,
      CELL_PUSH
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        capture;
      logic        shift;
   } cell_ctl_type;

endpackage

>>> src/ird_req_if.sv
// Request channel: valid, ready and the request word.
interface ird_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic signed [4:0] position;
   logic [63:0]       value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink (input valid, input kind, input position, input value, output ready);
endinterface

>>> src/ird_rsp_if.sv
// Response channel: valid, ready and the result word.
interface ird_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] data_out;
   logic [4:0]  length;

   modport source (output valid, output status, output data_out, output length, input ready);
   modport sink (input valid, input status, input data_out, input length, output ready);
endinterface

>>> src/ird_cell.sv
// One storage cell of the deque chain with its read-out tap.
module ird_cell #(
   parameter int CAPACITY = 16,
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  ird_pkg::cell_ctl_type               ctl,
   input  logic [$clog2(CAPACITY)-1:0]         target,
   input  logic [ird_pkg::WORD_W-1:0]          value,
   input  logic [ird_pkg::WORD_W-1:0]          left_data,
   input  logic [ird_pkg::WORD_W-1:0]          right_data,
   input  logic [ird_pkg::WORD_W-1:0]          right_tap,
   output logic [ird_pkg::WORD_W-1:0]          data,
   output logic [ird_pkg::WORD_W-1:0]          tap
);
   import ird_pkg::*;

   localparam int IW = $clog2(CAPACITY);

   logic [WORD_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] tap_ff, tap_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         CELL_HOLD: data_in = data_ff;
         CELL_WRITE: begin
            if (target == IW'(INDEX)) data_in = value;
         end
         CELL_PULL: begin
            if (IW'(INDEX) >= target) data_in = right_data;
         end
         CELL_PUSH: data_in = left_data;
         default: data_in = data_ff;
      endcase
   end

   always_comb begin
      priority if (ctl.capture) begin
         tap_in = data_ff;
      end else if (ctl.shift) begin
         tap_in = right_tap;
      end else begin
         tap_in = tap_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data = data_ff;
   assign tap  = tap_ff;
endmodule

>>> src/ird_ctrl.sv
// Request decode, length tracking, read sequencing and response register.
module ird_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ird_req_if.sink                             req,
   ird_rsp_if.source                           rsp,
   output ird_pkg::cell_ctl_type               ctl,
   output logic [$clog2(CAPACITY)-1:0]         target,
   input  logic [ird_pkg::WORD_W-1:0]          head_data,
   input  logic [ird_pkg::WORD_W-1:0]          head_tap
);
   import ird_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CALC_W = (CW > POS_W + 1) ? CW : POS_W + 1;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] remain_ff, remain_in;
   status_type pend_status_ff, pend_status_in;
   logic [WORD_W-1:0] pend_data_ff, pend_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic [LEN_W-1:0] rsp_length_ff;

   logic accept, deliver;
   logic full, empty, hit, need_read;
   logic [CALC_W-1:0] pos_w, mag_w, count_w, idx_w;
   logic [IW-1:0] idx, read_idx, op_target;
   cell_op_type op;
   status_type status;
   logic [CW-1:0] count_next;
   logic [WORD_W-1:0] imm_data;

   assign accept  = req.valid && req.ready;
   assign deliver = (state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      full    = (count_ff == CW'(CAPACITY));
      empty   = (count_ff == '0);
      pos_w   = CALC_W'({1'b0, req.position});
      mag_w   = CALC_W'(6'd32 - {1'b0, req.position});
      count_w = CALC_W'(count_ff);
      hit     = req.position[POS_W-1] ? (mag_w <= count_w) : (pos_w < count_w);
      idx_w   = req.position[POS_W-1] ? (count_w - mag_w) : pos_w;
      idx     = IW'(idx_w);
   end

   always_comb begin
      op         = CELL_HOLD;
      op_target  = idx;
      status     = STATUS_OK;
      count_next = count_ff;
      need_read  = 1'b0;
      read_idx   = idx;
      imm_data   = '0;
      unique case (kind_type'(req.kind))
         KIND_PUSH_BACK: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               op         = CELL_WRITE;
               op_target  = IW'(count_ff);
               count_next = count_ff + CW'(1);
            end
         end
         KIND_PUSH_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               op         = CELL_PUSH;
               count_next = count_ff + CW'(1);
            end
         end
         KIND_POP_BACK: begin
            if (empty) begin
               status = STATUS_NONE;
            end else begin
               need_read  = 1'b1;
               read_idx   = IW'(count_ff - CW'(1));
               count_next = count_ff - CW'(1);
            end
         end
         KIND_POP_FRONT: begin
            if (empty) begin
               status = STATUS_NONE;
            end else begin
               op         = CELL_PULL;
               op_target  = '0;
               imm_data   = head_data;
               count_next = count_ff - CW'(1);
            end
         end
         KIND_GET: begin
            if (hit) need_read = 1'b1;
            else status = STATUS_NONE;
         end
         KIND_SET: begin
            if (hit) op = CELL_WRITE;
            else status = STATUS_NONE;
         end
         KIND_REMOVE: begin
            if (hit) begin
               op         = CELL_PULL;
               count_next = count_ff - CW'(1);
            end else begin
               status = STATUS_NONE;
            end
         end
         default: status = STATUS_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = need_read ? ST_READ : ST_DELIVER;
         end
         ST_READ: begin
            if (remain_ff == '0) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (deliver) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready      = (state_ff == ST_IDLE);
      ctl.op         = CELL_HOLD;
      ctl.capture    = 1'b0;
      ctl.shift      = 1'b0;
      target         = op_target;
      count_in       = count_ff;
      remain_in      = remain_ff;
      pend_status_in = pend_status_ff;
      pend_data_in   = pend_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.op         = op;
               ctl.capture    = 1'b1;
               count_in       = count_next;
               remain_in      = read_idx;
               pend_status_in = status;
               pend_data_in   = imm_data;
            end
         end
         ST_READ: begin
            if (remain_ff == '0) begin
               pend_data_in = head_tap;
            end else begin
               ctl.shift = 1'b1;
               remain_in = remain_ff - IW'(1);
            end
         end
         ST_DELIVER: begin
            if (deliver) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff      <= remain_in;
      pend_status_ff <= pend_status_in;
      pend_data_ff   <= pend_data_in;
      if (deliver) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= pend_data_ff;
         rsp_length_ff <= LEN_W'(count_ff);
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.data_out = rsp_data_ff;
   assign rsp.length   = rsp_length_ff;
endmodule

>>> src/indexed_ring_deque.sv
// Top level: a chain of storage cells in logical order under one controller.
// Push, pop_front, set, remove and refused requests: the result passes the deliver
// state into the response register; no new request is taken until it is there.
// Get and pop_back: the tap chain walks the word to cell 0 one cell a cycle,
// then the result passes the deliver state into the response register.
// Reset clears the length and the handshake state; cell contents are left as they are.
module indexed_ring_deque #(
   parameter int CAPACITY = ird_pkg::DEFAULT_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   ird_req_if.sink   req,
   ird_rsp_if.source rsp
);
   import ird_pkg::*;

   localparam int IW = $clog2(CAPACITY);

   cell_ctl_type ctl;
   logic [IW-1:0] target;
   logic [WORD_W-1:0] cell_data [CAPACITY];
   logic [WORD_W-1:0] cell_tap [CAPACITY];

   ird_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .ctl       (ctl),
      .target    (target),
      .head_data (cell_data[0]),
      .head_tap  (cell_tap[0])
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_W-1:0] left_data, right_data, right_tap;

      if (g == 0) begin : g_first
         assign left_data = req.value;
      end else begin : g_inner
         assign left_data = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_data = '0;
         assign right_tap  = '0;
      end else begin : g_mid
         assign right_data = cell_data[g+1];
         assign right_tap  = cell_tap[g+1];
      end

      ird_cell #(.CAPACITY(CAPACITY), .INDEX(g)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .target     (target),
         .value      (req.value),
         .left_data  (left_data),
         .right_data (right_data),
         .right_tap  (right_tap),
         .data       (cell_data[g]),
         .tap        (cell_tap[g])
      );
   end
endmodule

>>> src/ird_checker.sv
// Port-level checks for the deque, bound to the top level.
module ird_checker #(
   parameter int CAPACITY = ird_pkg::DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_data_out,
   input logic [4:0]  rsp_length
);
   import ird_pkg::*;

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_data_out == '0)
      else $error("failed request returned data");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_length == 5'(CAPACITY))
      else $error("full status below capacity");

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_length) <= CAPACITY)
      else $error("length above capacity");
endmodule

bind indexed_ring_deque ird_checker #(.CAPACITY(CAPACITY)) u_ird_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_status   (rsp.status),
   .rsp_data_out (rsp.data_out),
   .rsp_length   (rsp.length)
);

>>> tb/tb_top.sv
// Self-checking testbench for the indexed ring deque.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ird_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int LEAN_NONE = 0;
   localparam int LEAN_FILL = 1;
   localparam int LEAN_DRAIN = 2;
   localparam int HOLD_CYCLES = 300;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct packed {
      status_type  status;
      logic [63:0] data;
      logic [4:0]  length;
   } deque_result_type;

   logic clock;
   logic reset;

   ird_req_if req_if ();
   ird_rsp_if rsp_if ();

   indexed_ring_deque #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   logic [63:0]      ring_slot [CAPACITY];
   int               ring_head = 0;
   int               ring_len = 0;
   deque_result_type pending_results [$];
   int               mismatch_count = 0;
   int               burst_left = 0;
   bit               gaps_off = 0;
   logic             hold_trigger = 1'b0;
   logic             hold_seen = 1'b0;
   int               hold_left = 0;
   int               rsp_mode = 0;
   int               rsp_cycle = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("indexed_ring_deque: mismatch");
      $finish;
   end

   function automatic bit resolve_position(input logic signed [4:0] pos, output int idx);
      int p;
      p = int'(pos);
      idx = 0;
      if (p < 0) begin
         if (-p > ring_len) return 1'b0;
         idx = ring_len + p;
         return 1'b1;
      end
      if (p >= ring_len) return 1'b0;
      idx = p;
      return 1'b1;
   endfunction

   function automatic deque_result_type apply_request(input logic [2:0] kind,
                                                      input logic signed [4:0] pos,
                                                      input logic [63:0] value);
      deque_result_type r;
      int idx;
      r.status = STATUS_OK;
      r.data = '0;
      idx = 0;
      case (kind)
         KIND_PUSH_BACK: begin
            if (ring_len >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               ring_slot[(ring_head + ring_len) % CAPACITY] = value;
               ring_len++;
            end
         end
         KIND_PUSH_FRONT: begin
            if (ring_len >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
               ring_slot[ring_head] = value;
               ring_len++;
            end
         end
         KIND_POP_BACK: begin
            if (ring_len == 0) begin
               r.status = STATUS_NONE;
            end else begin
               ring_len--;
               r.data = ring_slot[(ring_head + ring_len) % CAPACITY];
            end
         end
         KIND_POP_FRONT: begin
            if (ring_len == 0) begin
               r.status = STATUS_NONE;
            end else begin
               r.data = ring_slot[ring_head];
               ring_head = (ring_head + 1) % CAPACITY;
               ring_len--;
            end
         end
         KIND_GET: begin
            if (resolve_position(pos, idx)) r.data = ring_slot[(ring_head + idx) % CAPACITY];
            else r.status = STATUS_NONE;
         end
         KIND_SET: begin
            if (resolve_position(pos, idx)) ring_slot[(ring_head + idx) % CAPACITY] = value;
            else r.status = STATUS_NONE;
         end
         KIND_REMOVE: begin
            if (resolve_position(pos, idx)) begin
               for (int i = idx; i + 1 < ring_len; i++) begin
                  ring_slot[(ring_head + i) % CAPACITY] =
                     ring_slot[(ring_head + i + 1) % CAPACITY];
               end
               ring_len--;
            end else begin
               r.status = STATUS_NONE;
            end
         end
         default: r.status = STATUS_NONE;
      endcase
      r.length = ring_len[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      deque_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            pending_results.push_back(apply_request(req_if.kind, req_if.position, req_if.value));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCHES) begin
                  $display("unexpected word: status %0d data %h length %0d",
                           rsp_if.status, rsp_if.data_out, rsp_if.length);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.status !== want.status || rsp_if.data_out !== want.data ||
                   rsp_if.length !== want.length) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOWN_MISMATCHES) begin
                     $display({"word mismatch: expected status %0d data %h length %0d, ",
                               "got status %0d data %h length %0d"},
                              want.status, want.data, want.length,
                              rsp_if.status, rsp_if.data_out, rsp_if.length);
                  end
               end
            end
         end
      end
   end

   // receiver: rsp_cycle sets when the random stall pattern is redrawn; a toggle of hold_trigger starts a long hold
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_cycle++;
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_cycle % 64 == 0) rsp_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rsp_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_word(input logic [2:0] kind, input logic signed [4:0] pos,
                            input logic [63:0] value);
      int gap;
      if (burst_left <= 0 && !gaps_off) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.position <= pos;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
   endtask

   function automatic logic [63:0] random_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_random_request(input int lean);
      int r;
      int push_cut;
      int pop_cut;
      logic [2:0] kind;
      logic signed [4:0] pos;
      r = $urandom_range(0, 99);
      push_cut = (lean == LEAN_FILL) ? 55 : (lean == LEAN_DRAIN) ? 15 : 35;
      pop_cut = push_cut + ((lean == LEAN_FILL) ? 10 : (lean == LEAN_DRAIN) ? 40 : 20);
      if (r < push_cut) kind = ($urandom_range(0, 1) == 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      else if (r < pop_cut) kind = ($urandom_range(0, 1) == 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      else if (r < 97) begin
         case ($urandom_range(0, 2))
            0: kind = KIND_GET;
            1: kind = KIND_SET;
            default: kind = KIND_REMOVE;
         endcase
      end else kind = KIND_UNUSED;
      if (ring_len > 0 && $urandom_range(0, 9) < 8) begin
         if ($urandom_range(0, 1) == 1) pos = 5'($urandom_range(0, ring_len - 1));
         else pos = 5'(-$urandom_range(1, ring_len));
      end else begin
         pos = 5'($urandom_range(0, 31));
      end
      send_word(kind, pos, random_value());
   endtask

   task automatic test_empty_requests();
      send_word(KIND_POP_BACK, 5'sd0, '1);
      send_word(KIND_POP_FRONT, 5'sd0, '0);
      send_word(KIND_GET, -5'sd1, '0);
      send_word(KIND_SET, 5'sd0, '1);
      send_word(KIND_REMOVE, -5'sd16, '0);
      send_word(KIND_UNUSED, 5'sd15, '1);
   endtask

   task automatic test_full_boundaries();
      send_word(KIND_PUSH_BACK, 5'sd0, '0);
      send_word(KIND_PUSH_FRONT, 5'sd0, '1);
      for (int i = 2; i < CAPACITY; i++) begin
         send_word((i % 2 == 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, 5'sd0, {$urandom, $urandom});
      end
      send_word(KIND_PUSH_BACK, 5'sd0, '1);
      send_word(KIND_PUSH_FRONT, 5'sd0, '1);
      send_word(KIND_GET, 5'sd15, '0);
      send_word(KIND_GET, -5'sd16, '0);
      send_word(KIND_SET, -5'sd1, '1);
      send_word(KIND_REMOVE, 5'sd7, '0);
      send_word(KIND_GET, 5'sd15, '0);
      send_word(KIND_REMOVE, -5'sd16, '0);
      send_word(KIND_POP_BACK, 5'sd0, '0);
      send_word(KIND_POP_FRONT, 5'sd0, '0);
   endtask

   task automatic test_random_mix(input int items);
      int lean;
      lean = LEAN_NONE;
      for (int n = 0; n < items; n++) begin
         if (n % 40 == 0) lean = $urandom_range(LEAN_NONE, LEAN_DRAIN);
         send_random_request(lean);
      end
   endtask

   task automatic test_receiver_hold();
      hold_trigger <= ~hold_trigger;
      gaps_off = 1;
      for (int n = 0; n < 40; n++) send_random_request(LEAN_FILL);
      gaps_off = 0;
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.kind <= KIND_PUSH_BACK;
      req_if.position <= '0;
      req_if.value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_requests();
      test_full_boundaries();
      test_random_mix(500);
      test_receiver_hold();
      test_random_mix(500);
      test_receiver_hold();

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("indexed_ring_deque: match");
      end else begin
         $display("indexed_ring_deque: mismatch");
      end
      $finish;
   end

endmodule

>>> indexed_ring_deque.f
src/ird_pkg.sv
src/ird_req_if.sv
src/ird_rsp_if.sv
src/ird_cell.sv
src/ird_ctrl.sv
src/indexed_ring_deque.sv
src/ird_checker.sv
tb/tb_top.sv
